FILE: design/jmss_pkg.sv
// ---------------------------------------------------------------------------
// jmss_pkg - shared types and constants for the JPEG marker segment scanner
// Byte request and result structs, marker codes, search phases and sub-states.
// ---------------------------------------------------------------------------
package jmss_pkg;

	localparam int unsigned POS_W = 21;
	localparam int unsigned OFS_W = 20;

	// frames longer than this are cut off with a frame-too-long result
	localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 21'd1048576;

	localparam logic [7:0] MARK_FRAMING = 8'hff;
	localparam logic [7:0] MARK_SOI     = 8'hd8;
	localparam logic [7:0] MARK_DQT     = 8'hdb;
	localparam logic [7:0] MARK_SOS     = 8'hda;
	localparam logic [7:0] MARK_EOI     = 8'hd9;

	localparam logic [2:0] PH_SOI  = 3'd0;
	localparam logic [2:0] PH_DQT0 = 3'd1;
	localparam logic [2:0] PH_DQT1 = 3'd2;
	localparam logic [2:0] PH_SOS  = 3'd3;
	localparam logic [2:0] PH_SCAN = 3'd4;
	localparam logic [2:0] PH_EOI  = 3'd5;
	localparam logic [2:0] PH_DONE = 3'd6;

	localparam logic [2:0] SUB_FRAME   = 3'd0;
	localparam logic [2:0] SUB_FLAG    = 3'd1;
	localparam logic [2:0] SUB_LENHI   = 3'd2;
	localparam logic [2:0] SUB_LENLO   = 3'd3;
	localparam logic [2:0] SUB_SKIP    = 3'd4;
	localparam logic [2:0] SUB_LENHI_M = 3'd5;
	localparam logic [2:0] SUB_LENLO_M = 3'd6;
	localparam logic [2:0] SUB_SKIP_M  = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SOI   = 2'd1;
	localparam logic [1:0] ST_NO_EOI   = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             table0_found;
		logic [OFS_W-1:0] table0_offset;
		logic             table1_found;
		logic [OFS_W-1:0] table1_offset;
		logic [POS_W-1:0] scan_start;
		logic [POS_W-1:0] scan_end;
	} result_t;

endpackage

FILE: design/jpeg_marker_segment_scanner.sv
// ---------------------------------------------------------------------------
// jpeg_marker_segment_scanner - locates SOI, two DQT, SOS and EOI in a frame
// Walks a JPEG frame byte by byte and reports table offsets and scan bounds.
// ---------------------------------------------------------------------------
// Usage
//   byte channel: one frame byte per request, last_byte set on the final byte.
//   result channel: one result per frame, issued with the last byte, or early
//   with status frame-too-long when a byte arrives at offset MAX_FRAME_BYTES
//   before EOI; the remaining bytes up to last_byte are then swallowed.
//   Throughput: one byte per cycle while byte_stall is low. The scan state updates in the cycle a
//   byte is taken; the result sits in the output register in the next cycle.
//   The output register decouples the two sides: a byte is taken whenever
//   the output register is empty or is being emptied in the same cycle, so
//   byte_stall only rises while a result waits and result_stall is high.
//   Reset clears the scan state and drops any pending result. After each
//   result on last_byte the scanner returns to its reset state on its own.
// ---------------------------------------------------------------------------
module jpeg_marker_segment_scanner (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  jmss_pkg::byte_t  byte_data,
	output logic             result_valid,
	input  logic             result_stall,
	output jmss_pkg::result_t result_data
);
	import jmss_pkg::*;

	logic [2:0]       phase_q, phase_d;
	logic [2:0]       sub_q, sub_d;
	logic [15:0]      skip_q, skip_d;
	logic [7:0]       lenhi_q, lenhi_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             pff_q, pff_d;
	logic             done_q, done_d;
	logic             f0_q, f0_d;
	logic             f1_q, f1_d;
	logic [OFS_W-1:0] o0_q, o0_d;
	logic [OFS_W-1:0] o1_q, o1_d;
	logic [POS_W-1:0] db_q, db_d;

	logic             res_valid_q;
	result_t          res_q;

	logic             take;
	logic             overflow;
	logic             run;
	logic             emit;
	logic             restart;
	logic [1:0]       status;
	logic [7:0]       b;

	// working copies
	logic [2:0]       mk_phase;
	logic [7:0]       target;
	logic             take_mark;
	logic             succ;
	logic             fail;
	logic             seg_match;
	logic [2:0]       base_sub;
	logic [15:0]      seg_len;
	logic [15:0]      skip_dec;
	logic             mk_match;
	logic [POS_W-1:0] pos_inc;

	assign take       = byte_valid & ~byte_stall;
	assign byte_stall = res_valid_q & result_stall;
	assign b          = byte_data.data_byte;
	assign overflow   = (phase_q != PH_DONE) && (pos_q >= MAX_FRAME_BYTES);
	assign run        = take && !done_q && (phase_q != PH_DONE) && !overflow;
	assign pos_inc    = pos_q + 21'd1;
	assign seg_len    = {lenhi_q, b};
	assign skip_dec   = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;
	assign seg_match  = (sub_q > SUB_SKIP);
	assign base_sub   = seg_match ? sub_q - 3'd3 : sub_q;

	always_comb begin
		phase_d   = phase_q;
		sub_d     = sub_q;
		skip_d    = skip_q;
		lenhi_d   = lenhi_q;
		pos_d     = pos_q;
		pff_d     = pff_q;
		f0_d      = f0_q;
		f1_d      = f1_q;
		o0_d      = o0_q;
		o1_d      = o1_q;
		db_d      = db_q;
		take_mark = 1'b0;
		succ      = 1'b0;
		fail      = 1'b0;
		mk_phase  = (phase_q == PH_SCAN) ? PH_EOI : phase_q;

		unique case (mk_phase)
			PH_SOI:           target = MARK_SOI;
			PH_DQT0, PH_DQT1: target = MARK_DQT;
			PH_SOS:           target = MARK_SOS;
			default:          target = MARK_EOI;
		endcase
		mk_match = (b == target);

		if (run) begin
			pos_d = pos_inc;
			if (phase_q == PH_SCAN) begin
				// 0xff followed by a nonzero byte ends the entropy data
				if (pff_q && b != 8'd0) begin
					pff_d     = 1'b0;
					phase_d   = PH_EOI;
					take_mark = 1'b1;
				end else begin
					pff_d = (b == MARK_FRAMING);
				end
			end else begin
				case (sub_q)
					SUB_FRAME: begin
						if (b != MARK_FRAMING) fail = 1'b1;
						else sub_d = SUB_FLAG;
					end
					SUB_FLAG: take_mark = 1'b1;
					default: begin
						case (base_sub)
							SUB_LENHI: begin
								lenhi_d = b;
								sub_d   = sub_q + 3'd1;
							end
							SUB_LENLO: begin
								if (seg_len < 16'd2) begin
									fail = 1'b1;
								end else begin
									skip_d = seg_len - 16'd2;
									if (seg_match) begin
										if (phase_q == PH_DQT0) f0_d = 1'b1;
										if (phase_q == PH_DQT1) f1_d = 1'b1;
										if (seg_len == 16'd2) succ = 1'b1;
										else sub_d = SUB_SKIP_M;
									end else begin
										sub_d = (seg_len == 16'd2) ? SUB_FRAME : SUB_SKIP;
									end
								end
							end
							default: begin
								skip_d = skip_dec;
								if (skip_dec == 16'd0) begin
									if (seg_match) succ = 1'b1;
									else sub_d = SUB_FRAME;
								end
							end
						endcase
					end
				endcase
			end

			if (take_mark) begin
				if (mk_match && mk_phase == PH_DQT0) o0_d = pos_q[OFS_W-1:0];
				if (mk_match && mk_phase == PH_DQT1) o1_d = pos_q[OFS_W-1:0];
				if (b == MARK_SOI || b == MARK_EOI) begin
					if (mk_match) succ = 1'b1;
					else sub_d = SUB_FRAME;
				end else begin
					sub_d = mk_match ? SUB_LENHI_M : SUB_LENHI;
				end
			end

			if (succ || fail) begin
				sub_d = SUB_FRAME;
				unique case (mk_phase)
					PH_SOI: begin
						if (succ) begin
							phase_d = PH_DQT0;
						end else begin
							phase_d = PH_DONE;
							sub_d   = {1'b0, ST_NO_SOI};
						end
					end
					PH_DQT0: phase_d = PH_DQT1;
					PH_DQT1: phase_d = PH_SOS;
					PH_SOS: begin
						phase_d = PH_SCAN;
						db_d    = pos_inc;
						pff_d   = 1'b0;
					end
					default: begin
						phase_d = PH_DONE;
						sub_d   = succ ? {1'b0, ST_OK} : {1'b0, ST_NO_EOI};
					end
				endcase
			end
		end
	end

	always_comb begin
		if (overflow) status = ST_TOO_LONG;
		else if (phase_d == PH_DONE) status = sub_d[1:0];
		else if (phase_d == PH_SOI) status = ST_NO_SOI;
		else status = ST_NO_EOI;
	end

	assign emit    = take && !done_q && (overflow || byte_data.last_byte);
	assign restart = take && byte_data.last_byte;
	// swallow mode holds until the last byte of the frame restarts the scanner
	assign done_d  = done_q || (take && overflow && !byte_data.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SOI;
			sub_q   <= SUB_FRAME;
			skip_q  <= '0;
			lenhi_q <= '0;
			pos_q   <= '0;
			pff_q   <= 1'b0;
			done_q  <= 1'b0;
			f0_q    <= 1'b0;
			f1_q    <= 1'b0;
			o0_q    <= '0;
			o1_q    <= '0;
			db_q    <= '0;
		end else if (restart) begin
			phase_q <= PH_SOI;
			sub_q   <= SUB_FRAME;
			skip_q  <= '0;
			lenhi_q <= '0;
			pos_q   <= '0;
			pff_q   <= 1'b0;
			done_q  <= 1'b0;
			f0_q    <= 1'b0;
			f1_q    <= 1'b0;
			o0_q    <= '0;
			o1_q    <= '0;
			db_q    <= '0;
		end else begin
			phase_q <= phase_d;
			sub_q   <= sub_d;
			skip_q  <= skip_d;
			lenhi_q <= lenhi_d;
			pos_q   <= pos_d;
			pff_q   <= pff_d;
			done_q  <= done_d;
			f0_q    <= f0_d;
			f1_q    <= f1_d;
			o0_q    <= o0_d;
			o1_q    <= o1_d;
			db_q    <= db_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.status        <= status;
			res_q.table0_found  <= f0_d;
			res_q.table0_offset <= f0_d ? o0_d : '0;
			res_q.table1_found  <= f1_d;
			res_q.table1_offset <= f1_d ? o1_d : '0;
			res_q.scan_start    <= db_d;
			res_q.scan_end      <= (status == ST_OK) ? pos_d : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

	// a byte is only held off while a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid)
		else $error("byte stalled with no result pending");

	// overflow swallow mode never coexists with the finished phase
	a_done_not_finished: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (phase_q != PH_DONE))
		else $error("overflow flag set in finished phase");

	// finished phase keeps a real status in the sub-state
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> (sub_q[2] == 1'b0 && sub_q[1:0] != ST_TOO_LONG))
		else $error("bad status held in finished phase");

	// pending 0xff only lives inside the entropy scan
	a_pff_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pff_q |-> (phase_q == PH_SCAN))
		else $error("pending 0xff outside entropy scan");

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb - self-checking bench for jpeg_marker_segment_scanner
// Feeds whole frames byte by byte: a few hand-built frames for the corner
// cases, then randomised frames (mostly well formed, some corrupted,
// truncated or pure noise).
// A scoreboard tracks the marker searches itself and checks every result
// field by field, while the sender pauses in bursts and the receiver stalls.
// ---------------------------------------------------------------------------
module tb;
	import jmss_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 1200;
	localparam int RANDOM_FRAMES = 40;

	class frame_scoreboard;
		logic [2:0]       phase;
		logic [2:0]       substate;
		logic [15:0]      skip_left;
		logic [7:0]       len_hi;
		logic [POS_W-1:0] pos;
		logic             ff_seen;
		logic             overflowed;
		logic             t0_found;
		logic             t1_found;
		logic [OFS_W-1:0] t0_ofs;
		logic [OFS_W-1:0] t1_ofs;
		logic [POS_W-1:0] scan_begin;
		result_t          expected_results[$];
		int               error_count;

		function new();
			clear();
			error_count = 0;
		endfunction

		function void clear();
			phase      = PH_SOI;
			substate   = SUB_FRAME;
			skip_left  = '0;
			len_hi     = '0;
			pos        = '0;
			ff_seen    = 1'b0;
			overflowed = 1'b0;
			t0_found   = 1'b0;
			t1_found   = 1'b0;
			t0_ofs     = '0;
			t1_ofs     = '0;
			scan_begin = '0;
		endfunction

		function logic [7:0] wanted_marker();
			case (phase)
				PH_SOI: return MARK_SOI;
				PH_DQT0, PH_DQT1: return MARK_DQT;
				PH_SOS: return MARK_SOS;
				default: return MARK_EOI;
			endcase
		endfunction

		// a search ends on a hit or a miss; the next one follows, but an SOI miss or any EOI outcome finishes the frame
		function void close_search(logic hit, logic [POS_W-1:0] next_pos);
			substate = SUB_FRAME;
			case (phase)
				PH_SOI: begin
					if (hit) begin
						phase = PH_DQT0;
					end else begin
						phase = PH_DONE;
						substate = {1'b0, ST_NO_SOI};
					end
				end
				PH_DQT0: phase = PH_DQT1;
				PH_DQT1: phase = PH_SOS;
				PH_SOS: begin
					phase = PH_SCAN;
					scan_begin = next_pos;
					ff_seen = 1'b0;
				end
				default: begin
					phase = PH_DONE;
					substate = hit ? {1'b0, ST_OK} : {1'b0, ST_NO_EOI};
				end
			endcase
		endfunction

		function void marker_byte(logic [POS_W-1:0] at, logic [7:0] b);
			logic hit;
			hit = (b == wanted_marker());
			if (hit && phase == PH_DQT0)
				t0_ofs = at[OFS_W-1:0];
			if (hit && phase == PH_DQT1)
				t1_ofs = at[OFS_W-1:0];
			if (b == MARK_SOI || b == MARK_EOI) begin
				if (hit)
					close_search(1'b1, at + 1'b1);
				else
					substate = SUB_FRAME;
			end else begin
				substate = hit ? SUB_LENHI_M : SUB_LENHI;
			end
		endfunction

		function void frame_byte(logic [POS_W-1:0] at, logic [7:0] b);
			logic        wanted;
			logic [15:0] seg_len;
			if (phase == PH_SCAN) begin
				// entropy data: only 0xff followed by a nonzero byte ends it
				if (ff_seen && b != 8'h00) begin
					ff_seen = 1'b0;
					phase = PH_EOI;
					marker_byte(at, b);
				end else begin
					ff_seen = (b == MARK_FRAMING);
				end
				return;
			end
			wanted = (substate > SUB_SKIP);
			case (substate)
				SUB_FRAME: begin
					if (b != MARK_FRAMING)
						close_search(1'b0, at + 1'b1);
					else
						substate = SUB_FLAG;
				end
				SUB_FLAG: marker_byte(at, b);
				SUB_LENHI, SUB_LENHI_M: begin
					len_hi = b;
					substate = substate + 3'd1;
				end
				SUB_LENLO, SUB_LENLO_M: begin
					seg_len = {len_hi, b};
					if (seg_len < 16'd2) begin
						close_search(1'b0, at + 1'b1);
					end else begin
						skip_left = seg_len - 16'd2;
						if (wanted) begin
							// a table counts once its length is valid
							if (phase == PH_DQT0)
								t0_found = 1'b1;
							if (phase == PH_DQT1)
								t1_found = 1'b1;
							if (skip_left == 16'd0)
								close_search(1'b1, at + 1'b1);
							else
								substate = SUB_SKIP_M;
						end else begin
							substate = (skip_left == 16'd0) ? SUB_FRAME : SUB_SKIP;
						end
					end
				end
				default: begin
					if (skip_left != 16'd0)
						skip_left = skip_left - 16'd1;
					if (skip_left == 16'd0) begin
						if (wanted)
							close_search(1'b1, at + 1'b1);
						else
							substate = SUB_FRAME;
					end
				end
			endcase
		endfunction

		function void push_result(logic [1:0] st);
			result_t r;
			r.status        = st;
			r.table0_found  = t0_found;
			r.table0_offset = t0_found ? t0_ofs : '0;
			r.table1_found  = t1_found;
			r.table1_offset = t1_found ? t1_ofs : '0;
			r.scan_start    = scan_begin;
			r.scan_end      = (st == ST_OK) ? pos : '0;
			expected_results.push_back(r);
		endfunction

		function void note_byte(byte_t item);
			logic [1:0] st;
			// after an overflow result the rest of the frame is swallowed
			if (overflowed) begin
				if (item.last_byte)
					clear();
				return;
			end
			if (phase != PH_DONE) begin
				if (pos >= MAX_FRAME_BYTES) begin
					push_result(ST_TOO_LONG);
					if (item.last_byte)
						clear();
					else
						overflowed = 1'b1;
					return;
				end
				frame_byte(pos, item.data_byte);
				pos = pos + 1'b1;
			end
			if (!item.last_byte)
				return;
			if (phase == PH_DONE)
				st = substate[1:0];
			else if (phase == PH_SOI)
				st = ST_NO_SOI;
			else
				st = ST_NO_EOI;
			push_result(st);
			clear();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				error_count++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result with no request waiting, expected none, actual %h",
					$time, got);
				error_count++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("table0_found", 32'(want.table0_found), 32'(got.table0_found));
			compare_field("table0_offset", 32'(want.table0_offset), 32'(got.table0_offset));
			compare_field("table1_found", 32'(want.table1_found), 32'(got.table1_found));
			compare_field("table1_offset", 32'(want.table1_offset), 32'(got.table1_offset));
			compare_field("scan_start", 32'(want.scan_start), 32'(got.scan_start));
			compare_field("scan_end", 32'(want.scan_end), 32'(got.scan_end));
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	byte_t   byte_data = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	frame_scoreboard sb = new();

	logic [7:0] frame_bytes[$];
	int         burst_left = 0;
	int         stall_mode = 0;
	int         stall_left = 0;
	int         idle_cycles = 0;

	jpeg_marker_segment_scanner dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				sb.check_result(result_data);
			if (byte_valid && !byte_stall)
				sb.note_byte(byte_data);
		end
	end

	// receiver: quiet stretches, toggling, random and heavy stalling
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 60);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= !result_stall;
			2: result_stall <= 1'($urandom_range(0, 1));
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		byte_valid <= 1'b1;
		byte_data <= '{data_byte: value, last_byte: is_last};
		do @(posedge clk); while (byte_stall);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	function automatic void add_marker(logic [7:0] marker);
		frame_bytes.push_back(MARK_FRAMING);
		frame_bytes.push_back(marker);
	endfunction

	function automatic void add_segment(logic [7:0] marker, logic [15:0] seg_len);
		add_marker(marker);
		frame_bytes.push_back(seg_len[15:8]);
		frame_bytes.push_back(seg_len[7:0]);
		for (int i = 2; i < int'(seg_len); i++)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// entropy bytes with 0xff always stuffed
	function automatic void add_entropy(int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			frame_bytes.push_back(b);
			if (b == MARK_FRAMING)
				frame_bytes.push_back(8'h00);
		end
	endfunction

	function automatic void build_good_frame();
		frame_bytes.delete();
		add_marker(MARK_SOI);
		repeat ($urandom_range(0, 2))
			add_segment(8'($urandom_range(8'he0, 8'hef)), 16'($urandom_range(2, 8)));
		add_segment(MARK_DQT, 16'($urandom_range(2, 10)));
		repeat ($urandom_range(0, 1))
			add_segment(8'($urandom_range(8'hc0, 8'hc4)), 16'($urandom_range(2, 6)));
		add_segment(MARK_DQT, 16'($urandom_range(2, 10)));
		repeat ($urandom_range(0, 2))
			add_segment(8'($urandom_range(8'hc0, 8'hc4)), 16'($urandom_range(2, 6)));
		add_segment(MARK_SOS, 16'($urandom_range(2, 8)));
		add_entropy($urandom_range(0, 20));
		add_marker(MARK_EOI);
		repeat ($urandom_range(0, 2))
			frame_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic run_directed();
		// lone bytes, no start of image
		frame_bytes = '{8'h00};
		send_frame();
		frame_bytes = '{MARK_FRAMING};
		send_frame();

		// shortest clean frame, stuffed byte, junk after the end of image
		frame_bytes.delete();
		add_marker(MARK_SOI);
		add_segment(MARK_DQT, 16'd2);
		add_segment(MARK_DQT, 16'd2);
		add_segment(MARK_SOS, 16'd2);
		frame_bytes.push_back(MARK_FRAMING);
		frame_bytes.push_back(8'h00);
		add_marker(MARK_EOI);
		frame_bytes.push_back(MARK_FRAMING);
		frame_bytes.push_back(MARK_FRAMING);
		send_frame();

		// bad framing, then lengths of one and of zero
		frame_bytes.delete();
		add_marker(MARK_SOI);
		frame_bytes.push_back(8'h12);
		add_segment(MARK_DQT, 16'd1);
		add_segment(MARK_SOS, 16'd0);
		frame_bytes.push_back(8'hab);
		frame_bytes.push_back(MARK_FRAMING);
		frame_bytes.push_back(8'h00);
		add_marker(MARK_EOI);
		send_frame();

		// table cut short by the end of the frame, maximum length
		frame_bytes.delete();
		add_marker(MARK_SOI);
		add_marker(MARK_DQT);
		frame_bytes.push_back(8'hff);
		frame_bytes.push_back(8'hff);
		frame_bytes.push_back(8'h11);
		send_frame();

		// image markers out of place, the end of image search failing on framing
		frame_bytes.delete();
		add_marker(MARK_SOI);
		add_marker(MARK_SOI);
		add_marker(MARK_EOI);
		add_segment(MARK_DQT, 16'd3);
		add_segment(MARK_DQT, 16'd2);
		add_segment(MARK_SOS, 16'd3);
		add_marker(8'h12);
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'h03);
		frame_bytes.push_back(8'h5a);
		frame_bytes.push_back(8'h34);
		frame_bytes.push_back(8'h56);
		send_frame();
	endtask

	initial begin
		int sent;
		int frames;
		int kind;
		int cut;
		sent = 0;
		frames = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (sent < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
			kind = $urandom_range(0, 9);
			build_good_frame();
			if (kind == 6 || kind == 7) begin
				repeat ($urandom_range(1, 3))
					frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
						($urandom_range(0, 2) == 0) ? MARK_FRAMING : 8'($urandom_range(0, 255));
			end else if (kind == 8) begin
				cut = $urandom_range(1, frame_bytes.size());
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end else if (kind == 9) begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 12))
					frame_bytes.push_back(8'($urandom_range(0, 255)));
			end
			send_frame();
			sent += frame_bytes.size();
			frames++;
		end
		byte_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
